// File: rtl/cc20_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types and constants for the ChaCha20 keystream core.
// ----------------------------------------------------------------------------
package cc20_pkg;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  localparam int CFG_AW = 3;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_KEY0      = 3'd0;
  localparam logic [CFG_AW-1:0] REG_KEY1      = 3'd1;
  localparam logic [CFG_AW-1:0] REG_KEY2      = 3'd2;
  localparam logic [CFG_AW-1:0] REG_KEY3      = 3'd3;
  localparam logic [CFG_AW-1:0] REG_NONCE_LO  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_NONCE_HI  = 3'd5;
  localparam logic [CFG_AW-1:0] REG_START_CTR = 3'd6;

  // classified item passed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic [5:0] pos;
    logic       fresh;   // first byte of a newly generated block
  } cmd_t;

  // request from front to block generator
  typedef struct packed {
    logic [31:0] counter;
    logic [31:0] nonce0;
  } blk_req_t;

  typedef logic [31:0] word16_t [16];

  function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

endpackage
`default_nettype wire

// File: rtl/cc20_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cc20 channel interfaces
// Valid/ready streams for input bytes, output bytes and configuration writes.
// ----------------------------------------------------------------------------
interface cc20_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       reload;
  logic       new_call;
  modport source (output valid, in_byte, reload, new_call, input ready);
  modport sink   (input valid, in_byte, reload, new_call, output ready);
endinterface

interface cc20_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  modport source (output valid, out_byte, input ready);
  modport sink   (input valid, out_byte, output ready);
endinterface

interface cc20_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/cc20_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cc20_core
// Iterative block generator: one quarter-round column/diagonal set per cycle
// (four quarter rounds in parallel), then feed-forward add.
// ----------------------------------------------------------------------------
module cc20_core
  import cc20_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire blk_req_t      req,
  input  wire logic [255:0]  key,
  input  wire logic [63:0]   nonce12,
  output logic               busy,
  output logic               done,
  output logic [511:0]       block
);

  localparam int HR = 2 * DOUBLE_ROUNDS;
  localparam int RW = $clog2(HR + 1);

  logic [31:0] init [16];
  logic [31:0] w    [16];
  logic [31:0] wn   [16];
  logic [RW-1:0] round;

  function automatic logic [127:0] qr(input logic [31:0] a, b, c, d);
    logic [31:0] a1, b1, c1, d1;
    a1 = a + b;  d1 = rotl(d ^ a1, 16);
    c1 = c + d1; b1 = rotl(b ^ c1, 12);
    a1 = a1 + b1; d1 = rotl(d1 ^ a1, 8);
    c1 = c1 + d1; b1 = rotl(b1 ^ c1, 7);
    return {a1, b1, c1, d1};
  endfunction

  // one half round: columns on even steps, diagonals on odd
  always_comb begin
    logic [127:0] r;
    for (int i = 0; i < 16; i++) wn[i] = w[i];
    for (int q = 0; q < 4; q++) begin
      if (!round[0]) begin
        r = qr(w[q], w[4+q], w[8+q], w[12+q]);
        {wn[q], wn[4+q], wn[8+q], wn[12+q]} = r;
      end else begin
        r = qr(w[q], w[4+(q+1)%4], w[8+(q+2)%4], w[12+(q+3)%4]);
        {wn[q], wn[4+(q+1)%4], wn[8+(q+2)%4], wn[12+(q+3)%4]} = r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      round <= '0;
    end else if (start && !busy) begin
      init[0] <= SIGMA0; init[1] <= SIGMA1; init[2] <= SIGMA2; init[3] <= SIGMA3;
      w[0] <= SIGMA0; w[1] <= SIGMA1; w[2] <= SIGMA2; w[3] <= SIGMA3;
      for (int i = 0; i < 8; i++) begin
        init[4+i] <= key[32*i +: 32];
        w[4+i]    <= key[32*i +: 32];
      end
      init[12] <= req.counter; w[12] <= req.counter;
      init[13] <= req.nonce0;  w[13] <= req.nonce0;
      init[14] <= nonce12[31:0];  w[14] <= nonce12[31:0];
      init[15] <= nonce12[63:32]; w[15] <= nonce12[63:32];
      busy  <= 1'b1;
      round <= '0;
    end else if (busy) begin
      if (round == RW'(HR)) begin
        for (int i = 0; i < 16; i++) block[32*i +: 32] <= w[i] + init[i];
        busy <= 1'b0;
      end else begin
        for (int i = 0; i < 16; i++) w[i] <= wn[i];
        round <= round + 1'b1;
      end
    end
  end

  // completion strobe, one cycle with the finished block
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= busy && (round == RW'(HR));
    end
  end

endmodule
`default_nettype wire

// File: rtl/cc20_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cc20_front
// Accepts input bytes, tracks byte position and counter, and issues block
// requests; pushes classified commands into the queue.
// ----------------------------------------------------------------------------
module cc20_front
  import cc20_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  cc20_in_if.sink          in_ch,
  input  wire logic [31:0] start_counter,
  input  wire logic [31:0] nonce0_cfg,
  input  wire logic        q_full,
  input  wire logic        gen_free,
  output logic             push,
  output cmd_t             cmd,
  output logic             gen_start,
  output blk_req_t         gen_req
);

  logic [31:0] counter;
  logic [31:0] nonce0;
  logic [6:0]  pos;
  logic        need;

  // a new block needs the generator free (previous block taken over as current by back)
  assign need = in_ch.reload || in_ch.new_call || pos[6];
  assign in_ch.ready = !q_full && (!need || gen_free);
  assign push = in_ch.valid && in_ch.ready;

  always_comb begin
    gen_req.counter = in_ch.reload ? start_counter : counter;
    gen_req.nonce0  = in_ch.reload ? nonce0_cfg : nonce0;
    gen_start = push && need;
    cmd.data  = in_ch.in_byte;
    cmd.pos   = need ? 6'd0 : pos[5:0];
    cmd.fresh = need;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
      nonce0  <= '0;
      pos     <= 7'd64;
    end else if (push) begin
      if (need) begin
        counter <= gen_req.counter + 32'd1;
        nonce0  <= (gen_req.counter == '1) ? gen_req.nonce0 + 32'd1 : gen_req.nonce0;
        pos     <= 7'd1;
      end else begin
        pos <= pos + 7'd1;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/cc20_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cc20_back
// Command queue plus keystream XOR stage with output register.
// ----------------------------------------------------------------------------
module cc20_back
  import cc20_pkg::*;
#(
  parameter int QDEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire cmd_t         cmd,
  output logic              q_full,
  input  wire logic         gen_done,
  input  wire logic [511:0] gen_block,
  output logic              gen_free,
  cc20_out_if.source        out_ch
);

  localparam int QW = $clog2(QDEPTH);

  cmd_t            q [QDEPTH];
  logic [QW-1:0]   wp, rp;
  logic [QW:0]     cnt;
  logic [511:0]    ks;
  logic            pend;      // generated block waiting to become current
  logic [511:0]    pend_blk;
  logic            inflight;  // block requested, not yet generated
  cmd_t            head;
  logic            pop, can;

  assign head   = q[rp];
  assign q_full = (cnt == (QW+1)'(QDEPTH));
  // one block in flight or waiting at most
  assign gen_free = !inflight && !pend;
  // a fresh head needs the pending block
  assign can  = (cnt != '0) && (!head.fresh || pend);
  assign pop  = can && (!out_ch.valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (push) q[wp] <= cmd;
    if (gen_done) pend_blk <= gen_block;
    if (pop) begin
      if (head.fresh) begin
        ks <= pend_blk;
        out_ch.out_byte <= head.data ^ pend_blk[8*head.pos +: 8];
      end else begin
        out_ch.out_byte <= head.data ^ ks[8*head.pos +: 8];
      end
    end
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
      pend <= 1'b0; inflight <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      cnt <= cnt + (QW+1)'(push) - (QW+1)'(pop);
      if (push && cmd.fresh) inflight <= 1'b1;
      else if (gen_done) inflight <= 1'b0;
      if (gen_done) pend <= 1'b1;
      else if (pop && head.fresh) pend <= 1'b0;
      if (pop) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: rtl/chacha20_stream_cipher_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_core
// ChaCha20 byte-stream XOR with configurable key, nonce and start counter.
// ----------------------------------------------------------------------------
// Channels: in_ch carries in_byte/reload/new_call, out_ch returns out_byte,
// cfg_ch writes registers (index 0..6: key parts, nonce low/high, start ctr).
// A byte inside a block passes through the queue and the output register at
// one byte per cycle while out_ch accepts. A byte opening a block (reload,
// new_call or 64 bytes used) starts the block generator: one half round per
// cycle through four parallel quarter-round units, plus the feed-forward add.
// That byte then passes the hand-off to the back and the output register.
// Generation starts when the first byte of a block is accepted; the bytes
// behind it fill the QDEPTH-deep queue, and in_ch stalls once it is full.
// Reset clears counter, nonce word 0, queue and marks no keystream left.
// When out_ch stalls the output register holds, the queue fills and in_ch
// ready drops; nothing is lost. cfg_ch is always ready.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_core
  import cc20_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = 10,
  parameter int QDEPTH        = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  cc20_in_if.sink    in_ch,
  cc20_out_if.source out_ch,
  cc20_cfg_if.sink   cfg_ch
);

  logic [63:0] kreg [4];
  logic [63:0] nonce_low;
  logic [31:0] nonce_high, start_counter;

  assign cfg_ch.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) kreg[i] <= '0;
      nonce_low <= '0; nonce_high <= '0; start_counter <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_KEY0:      kreg[0] <= cfg_ch.data;
        REG_KEY1:      kreg[1] <= cfg_ch.data;
        REG_KEY2:      kreg[2] <= cfg_ch.data;
        REG_KEY3:      kreg[3] <= cfg_ch.data;
        REG_NONCE_LO:  nonce_low <= cfg_ch.data;
        REG_NONCE_HI:  nonce_high <= cfg_ch.data[31:0];
        REG_START_CTR: start_counter <= cfg_ch.data[31:0];
        default: ;
      endcase
    end
  end

  logic         push, q_full, gen_free, gen_start, gen_busy, gen_done;
  cmd_t         cmd;
  blk_req_t     gen_req;
  logic [511:0] gen_block;

  cc20_front u_front (
    .clk, .rst, .in_ch,
    .start_counter, .nonce0_cfg(nonce_low[31:0]),
    .q_full, .gen_free, .push, .cmd, .gen_start, .gen_req
  );

  cc20_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core (
    .clk, .rst, .start(gen_start), .req(gen_req),
    .key({kreg[3], kreg[2], kreg[1], kreg[0]}),
    .nonce12({nonce_high, nonce_low[63:32]}),
    .busy(gen_busy), .done(gen_done), .block(gen_block)
  );

  cc20_back #(.QDEPTH(QDEPTH)) u_back (
    .clk, .rst, .push, .cmd, .q_full,
    .gen_done, .gen_block, .gen_free, .out_ch
  );

`ifndef SYNTH
  // a block start must never hit a busy generator
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    gen_start |-> !gen_busy) else $error("block start while generator busy");
  // completion only follows a running generator
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    gen_done |-> $past(gen_busy)) else $error("done without busy");
  // no push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full) else $error("queue overflow");
`endif

endmodule
`default_nettype wire
